@@ design/rcsd_pkg.sv @@
// Shared types, phase codes and constants for the RTMP chunk stream deframer.
package rcsd_pkg;

  localparam int NUM_STREAMS_DEF = 64;
  localparam int CSID_W          = 17;
  localparam logic [23:0] M24    = 24'hFFFFFF;
  localparam logic [23:0] CHUNK_SIZE_RST = 24'd128;

  // parse phases
  localparam logic [3:0] PH_BH0    = 4'd0;
  localparam logic [3:0] PH_BH1    = 4'd1;
  localparam logic [3:0] PH_BH2    = 4'd2;
  localparam logic [3:0] PH_TS     = 4'd3;
  localparam logic [3:0] PH_LEN    = 4'd4;
  localparam logic [3:0] PH_TYPE   = 4'd5;
  localparam logic [3:0] PH_SID    = 4'd6;
  localparam logic [3:0] PH_EXT    = 4'd7;
  localparam logic [3:0] PH_DATA   = 4'd8;
  localparam logic [3:0] PH_LOOKUP = 4'd9;

  localparam logic [1:0] FMT0 = 2'd0;
  localparam logic [1:0] FMT1 = 2'd1;
  localparam logic [1:0] FMT2 = 2'd2;
  localparam logic [1:0] FMT3 = 2'd3;

  // one entry of the per-stream table
  typedef struct packed {
    logic [31:0] ts;
    logic [31:0] delta;
    logic [23:0] len;
    logic [7:0]  mtype;
    logic [31:0] msg_id;
    logic        ext;
    logic [23:0] rcv;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // one result item
  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        has_data;
    logic [5:0]  stream_index;
    logic [7:0]  message_type;
    logic [23:0] message_length;
    logic [31:0] message_stream_id;
    logic [31:0] timestamp;
    logic        last_of_chunk;
    logic        last_of_message;
    logic        error;
  } res_t;

  // parser status toward the top level
  typedef struct packed {
    logic res_valid;
    logic lookup;
  } pstat_t;

endpackage

@@ design/rcsd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rcsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/rcsd_parser.sv @@
// Header parser, working copy of the current stream entry and result generation.
module rcsd_parser #(
  parameter int NUM_STREAMS = rcsd_pkg::NUM_STREAMS_DEF,
  localparam int AW = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [7:0]           byte_in,
  input  logic                 go,
  input  logic                 cfg_we,
  input  logic [23:0]          cfg_wdata,
  input  rcsd_pkg::entry_t     rd_entry,
  output logic                 rd_en,
  output logic [AW-1:0]        rd_addr,
  output logic                 wr_en,
  output logic [AW-1:0]        wr_addr,
  output rcsd_pkg::entry_t     wr_entry,
  output rcsd_pkg::pstat_t     stat,
  output rcsd_pkg::res_t       res
);
  import rcsd_pkg::*;

  localparam logic [CSID_W-1:0] NUM_CSID = CSID_W'(NUM_STREAMS);

  logic [3:0]        phase_r, phase_nxt;
  logic [2:0]        fbc_r, fbc_nxt;
  logic [1:0]        fmt_r, fmt_nxt;
  logic [CSID_W-1:0] cstr_r, cstr_nxt;
  logic [31:0]       shift_r, shift_nxt;
  logic [23:0]       left_r, left_nxt;
  logic              halted_r, halted_nxt;
  logic [23:0]       cs_r;
  entry_t            w_r, w_nxt;

  logic        do_after, do_hend;
  logic [23:0] space, cs_eff, n_bytes, rcv_inc;
  logic        lm, lc;

  always_comb begin
    phase_nxt  = phase_r;
    fbc_nxt    = fbc_r;
    fmt_nxt    = fmt_r;
    cstr_nxt   = cstr_r;
    shift_nxt  = shift_r;
    left_nxt   = left_r;
    halted_nxt = halted_r;
    w_nxt      = w_r;
    do_after   = 1'b0;
    do_hend    = 1'b0;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    stat.res_valid = 1'b0;
    stat.lookup    = (phase_r == PH_LOOKUP) && !halted_r;
    res        = '0;
    space      = '0;
    cs_eff     = '0;
    n_bytes    = '0;
    rcv_inc    = '0;
    lm         = 1'b0;
    lc         = 1'b0;

    if (!halted_r && phase_r == PH_LOOKUP && go) begin
      // table data is in: finish the basic header
      if (cstr_r >= NUM_CSID) begin
        halted_nxt         = 1'b1;
        stat.res_valid     = 1'b1;
        res.stream_index   = cstr_r[5:0];
        res.error          = 1'b1;
      end else begin
        w_nxt = rd_entry;
        if (fmt_r == FMT3) begin
          do_after = 1'b1;
        end else begin
          phase_nxt = PH_TS;
          fbc_nxt   = '0;
          shift_nxt = '0;
        end
      end
    end else if (!halted_r && step) begin
      case (phase_r)
        PH_BH0: begin
          fmt_nxt = byte_in[7:6];
          if (byte_in[5:1] == 5'd0) begin
            shift_nxt = {31'd0, byte_in[0]};
            cstr_nxt  = CSID_W'(64);
            phase_nxt = PH_BH1;
          end else begin
            cstr_nxt  = {{(CSID_W-6){1'b0}}, byte_in[5:0]};
            phase_nxt = PH_LOOKUP;
            rd_en     = 1'b1;
          end
        end
        PH_BH1: begin
          cstr_nxt = CSID_W'(64) + {{(CSID_W-8){1'b0}}, byte_in};
          if (shift_r[0]) begin
            phase_nxt = PH_BH2;
          end else begin
            phase_nxt = PH_LOOKUP;
            rd_en     = 1'b1;
          end
        end
        PH_BH2: begin
          cstr_nxt  = cstr_r + {1'b0, byte_in, 8'd0};
          phase_nxt = PH_LOOKUP;
          rd_en     = 1'b1;
        end
        PH_TS: begin
          shift_nxt = {shift_r[23:0], byte_in};
          fbc_nxt   = fbc_r + 3'd1;
          if (fbc_nxt == 3'd3) begin
            w_nxt.ext = (shift_nxt[23:0] == M24);
            if (fmt_r == FMT0) begin
              w_nxt.ts    = {8'd0, shift_nxt[23:0]};
              w_nxt.delta = '0;
            end else begin
              w_nxt.delta = {8'd0, shift_nxt[23:0]};
            end
            if (fmt_r == FMT2) begin
              do_after = 1'b1;
            end else begin
              phase_nxt = PH_LEN;
              fbc_nxt   = '0;
              shift_nxt = '0;
            end
          end
        end
        PH_LEN: begin
          shift_nxt = {shift_r[23:0], byte_in};
          fbc_nxt   = fbc_r + 3'd1;
          if (fbc_nxt == 3'd3) begin
            w_nxt.len = shift_nxt[23:0];
            phase_nxt = PH_TYPE;
            fbc_nxt   = '0;
            shift_nxt = '0;
          end
        end
        PH_TYPE: begin
          w_nxt.mtype = byte_in;
          if (fmt_r == FMT0) begin
            phase_nxt = PH_SID;
            fbc_nxt   = '0;
            shift_nxt = '0;
          end else begin
            do_after = 1'b1;
          end
        end
        PH_SID: begin
          // message stream id is little endian
          shift_nxt[fbc_r[1:0]*8 +: 8] = shift_r[fbc_r[1:0]*8 +: 8] | byte_in;
          fbc_nxt = fbc_r + 3'd1;
          if (fbc_nxt == 3'd4) begin
            w_nxt.msg_id = shift_nxt;
            do_after     = 1'b1;
          end
        end
        PH_EXT: begin
          shift_nxt = {shift_r[23:0], byte_in};
          fbc_nxt   = fbc_r + 3'd1;
          if (fbc_nxt == 3'd4) begin
            if (fmt_r == FMT0) begin
              w_nxt.ts = shift_nxt;
            end else if (!(fmt_r == FMT3 && w_r.rcv != 24'd0)) begin
              w_nxt.delta = shift_nxt;
            end
            do_hend = 1'b1;
          end
        end
        PH_DATA: begin
          rcv_inc  = w_r.rcv + 24'd1;
          lm       = (rcv_inc >= w_r.len);
          left_nxt = left_r - 24'd1;
          lc       = (left_nxt == 24'd0);
          w_nxt.rcv = lm ? 24'd0 : rcv_inc;
          stat.res_valid        = 1'b1;
          res.payload_byte      = byte_in;
          res.has_data          = 1'b1;
          res.stream_index      = cstr_r[5:0];
          res.message_type      = w_nxt.mtype;
          res.message_length    = w_nxt.len;
          res.message_stream_id = w_nxt.msg_id;
          res.timestamp         = w_nxt.ts;
          res.last_of_chunk     = lc;
          res.last_of_message   = lm;
          if (lc) begin
            phase_nxt = PH_BH0;
            fbc_nxt   = '0;
            shift_nxt = '0;
            wr_en     = 1'b1;
          end
        end
        default: begin
          phase_nxt = PH_BH0;
          fbc_nxt   = '0;
          shift_nxt = '0;
        end
      endcase
    end

    // extended timestamp follows, or the header is done
    if (do_after) begin
      if (w_nxt.ext) begin
        phase_nxt = PH_EXT;
        fbc_nxt   = '0;
        shift_nxt = '0;
      end else begin
        do_hend = 1'b1;
      end
    end

    // end of chunk header
    if (do_hend) begin
      if (fmt_r == FMT1 || fmt_r == FMT2 || (fmt_r == FMT3 && w_nxt.rcv == 24'd0)) begin
        w_nxt.ts = w_nxt.ts + w_nxt.delta;
      end
      space   = (w_nxt.len > w_nxt.rcv) ? (w_nxt.len - w_nxt.rcv) : 24'd0;
      cs_eff  = (cs_r != 24'd0) ? cs_r : 24'd1;
      n_bytes = (space < cs_eff) ? space : cs_eff;
      phase_nxt = PH_BH0;
      fbc_nxt   = '0;
      shift_nxt = '0;
      if (n_bytes == 24'd0) begin
        w_nxt.rcv             = '0;
        wr_en                 = 1'b1;
        stat.res_valid        = 1'b1;
        res.stream_index      = cstr_r[5:0];
        res.message_type      = w_nxt.mtype;
        res.message_length    = w_nxt.len;
        res.message_stream_id = w_nxt.msg_id;
        res.timestamp         = w_nxt.ts;
        res.last_of_chunk     = 1'b1;
        res.last_of_message   = 1'b1;
      end else begin
        left_nxt  = n_bytes;
        phase_nxt = PH_DATA;
      end
    end
  end

  // table addresses: out-of-range ids read entry zero and halt anyway
  assign rd_addr  = (cstr_nxt < NUM_CSID) ? cstr_nxt[AW-1:0] : '0;
  assign wr_addr  = cstr_r[AW-1:0];
  assign wr_entry = w_nxt;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_BH0;
      fbc_r    <= '0;
      fmt_r    <= '0;
      cstr_r   <= '0;
      shift_r  <= '0;
      left_r   <= '0;
      halted_r <= 1'b0;
      cs_r     <= CHUNK_SIZE_RST;
    end else begin
      phase_r  <= phase_nxt;
      fbc_r    <= fbc_nxt;
      fmt_r    <= fmt_nxt;
      cstr_r   <= cstr_nxt;
      shift_r  <= shift_nxt;
      left_r   <= left_nxt;
      halted_r <= halted_nxt;
      if (cfg_we) begin
        cs_r <= cfg_wdata;
      end
    end
  end

  // working entry
  always_ff @(posedge clk) begin
    w_r <= w_nxt;
  end

endmodule

@@ design/rtmp_chunk_stream_deframer_core.sv @@
// Top level of the RTMP chunk stream deframer: stream table, clearing pass, output register.
//
//  channel | signals                              | transfer
//  --------+--------------------------------------+------------------------------
//  in      | in_valid, in_ready, in_byte          | one stream byte per request
//  out     | out_valid, out_ready, out_* fields   | one tagged result per request
//  cfg     | cfg_valid, cfg_ready, cfg_chunk_size | chunk size write, always ready
//
// Payload and header bytes are taken one per cycle while in_ready is high. When a basic
// header completes, the stream table RAM is read and in_ready stays low until the
// looked-up entry is taken in. After reset a clearing pass writes every table entry
// with in_ready low. A stalled output register holds input off only when full.
module rtmp_chunk_stream_deframer_core #(
  parameter int NUM_STREAMS = rcsd_pkg::NUM_STREAMS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_payload_byte,
  output logic        out_has_data,
  output logic [5:0]  out_stream_index,
  output logic [7:0]  out_message_type,
  output logic [23:0] out_message_length,
  output logic [31:0] out_message_stream_id,
  output logic [31:0] out_timestamp,
  output logic        out_last_of_chunk,
  output logic        out_last_of_message,
  output logic        out_error,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_chunk_size
);
  import rcsd_pkg::*;

  localparam int AW = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_STREAMS - 1);

  logic          clearing_r;
  logic [AW-1:0] clr_r;
  logic          out_free, step, go;
  logic          p_rd_en, p_wr_en, ram_we;
  logic [AW-1:0] p_rd_addr, p_wr_addr, ram_waddr;
  entry_t        p_wr_entry, rd_entry, ram_wdata;
  pstat_t        stat;
  res_t          res, out_r;
  logic          out_valid_r;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = !clearing_r && out_free && !stat.lookup;
  assign step      = in_valid && in_ready;
  assign go        = out_free && !clearing_r;
  assign cfg_ready = 1'b1;

  rcsd_parser #(.NUM_STREAMS(NUM_STREAMS)) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .byte_in   (in_byte),
    .go        (go),
    .cfg_we    (cfg_valid),
    .cfg_wdata (cfg_chunk_size),
    .rd_entry  (rd_entry),
    .rd_en     (p_rd_en),
    .rd_addr   (p_rd_addr),
    .wr_en     (p_wr_en),
    .wr_addr   (p_wr_addr),
    .wr_entry  (p_wr_entry),
    .stat      (stat),
    .res       (res)
  );

  // clearing pass owns the write port after reset
  assign ram_we    = clearing_r || p_wr_en;
  assign ram_waddr = clearing_r ? clr_r : p_wr_addr;
  assign ram_wdata = clearing_r ? '0 : p_wr_entry;

  rcsd_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_STREAMS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (p_rd_en),
    .raddr (p_rd_addr),
    .rdata (rd_entry)
  );

  // clear sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_r      <= '0;
    end else if (clearing_r) begin
      clr_r <= clr_r + AW'(1);
      if (clr_r == LAST_ADDR) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= stat.res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && stat.res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_payload_byte      = out_r.payload_byte;
  assign out_has_data          = out_r.has_data;
  assign out_stream_index      = out_r.stream_index;
  assign out_message_type      = out_r.message_type;
  assign out_message_length    = out_r.message_length;
  assign out_message_stream_id = out_r.message_stream_id;
  assign out_timestamp         = out_r.timestamp;
  assign out_last_of_chunk     = out_r.last_of_chunk;
  assign out_last_of_message   = out_r.last_of_message;
  assign out_error             = out_r.error;

endmodule

@@ test/rtmp_chunk_stream_deframer_core_tb.sv @@
// Testbench for the RTMP chunk stream deframer core: predictor, scoreboard and stimulus.
`timescale 1ns / 1ps

module rtmp_chunk_stream_deframer_core_tb;
  import rcsd_pkg::*;

  localparam int STREAMS = NUM_STREAMS_DEF;
  localparam int WATCHDOG_LIMIT = 20000;

  // deframer predictor plus the queue of results it still expects
  class deframe_scoreboard;
    logic [23:0] chunk_size;
    logic [3:0]  phase;
    int unsigned field_cnt;
    logic [1:0]  fmt;
    int unsigned cur_id;
    logic [31:0] shift;
    logic [23:0] bytes_left;
    bit          halted;
    logic [31:0] tbl_ts    [STREAMS];
    logic [31:0] tbl_delta [STREAMS];
    logic [23:0] tbl_len   [STREAMS];
    logic [7:0]  tbl_type  [STREAMS];
    logic [31:0] tbl_msgid [STREAMS];
    bit          tbl_ext   [STREAMS];
    logic [23:0] tbl_rcv   [STREAMS];
    res_t        expected_results[$];
    int          errors;

    function new();
      chunk_size = CHUNK_SIZE_RST;
      phase = PH_BH0;
      field_cnt = 0;
      fmt = FMT0;
      cur_id = 0;
      shift = '0;
      bytes_left = '0;
      halted = 0;
      errors = 0;
      for (int i = 0; i < STREAMS; i++) begin
        tbl_ts[i] = '0; tbl_delta[i] = '0; tbl_len[i] = '0; tbl_type[i] = '0;
        tbl_msgid[i] = '0; tbl_ext[i] = 0; tbl_rcv[i] = '0;
      end
    endfunction

    function int unsigned idx();
      return (cur_id < STREAMS) ? cur_id : 0;
    endfunction

    function void next_field(logic [3:0] ph);
      phase = ph;
      field_cnt = 0;
      shift = '0;
    endfunction

    function res_t tagged_result(int unsigned s, logic [7:0] b, bit has, bit lc, bit lm);
      res_t r;
      r = '0;
      r.payload_byte = b;
      r.has_data = has;
      r.stream_index = cur_id[5:0];
      r.message_type = tbl_type[s];
      r.message_length = tbl_len[s];
      r.message_stream_id = tbl_msgid[s];
      r.timestamp = tbl_ts[s];
      r.last_of_chunk = lc;
      r.last_of_message = lm;
      return r;
    endfunction

    function bit header_end(output res_t r);
      int unsigned s;
      logic [23:0] space, n, cs;
      s = idx();
      r = '0;
      cs = (chunk_size == 0) ? 24'd1 : chunk_size;
      if (fmt == FMT1 || fmt == FMT2 || (fmt == FMT3 && tbl_rcv[s] == 0))
        tbl_ts[s] = tbl_ts[s] + tbl_delta[s];
      space = (tbl_len[s] > tbl_rcv[s]) ? tbl_len[s] - tbl_rcv[s] : 24'd0;
      n = (space < cs) ? space : cs;
      next_field(PH_BH0);
      if (n == 0) begin
        tbl_rcv[s] = '0;
        r = tagged_result(s, 8'd0, 0, 1, 1);
        return 1;
      end
      bytes_left = n;
      phase = PH_DATA;
      return 0;
    endfunction

    function bit after_fields(output res_t r);
      r = '0;
      if (tbl_ext[idx()]) begin
        next_field(PH_EXT);
        return 0;
      end
      return header_end(r);
    endfunction

    function bit basic_done(output res_t r);
      r = '0;
      // out-of-range stream id: error request, then silent until reset
      if (cur_id >= STREAMS) begin
        halted = 1;
        r.stream_index = cur_id[5:0];
        r.error = 1'b1;
        return 1;
      end
      if (fmt == FMT3) return after_fields(r);
      next_field(PH_TS);
      return 0;
    endfunction

    function bit step(input logic [7:0] b, output res_t r);
      int unsigned s;
      logic [23:0] v, nr;
      bit lm, lc;
      r = '0;
      if (halted) return 0;
      s = idx();
      case (phase)
        PH_BH0: begin
          fmt = b[7:6];
          cur_id = b[5:0];
          if (cur_id < 2) begin
            shift = cur_id;
            cur_id = 64;
            phase = PH_BH1;
            return 0;
          end
          return basic_done(r);
        end
        PH_BH1: begin
          cur_id = 64 + b;
          if (shift == 1) begin
            phase = PH_BH2;
            return 0;
          end
          return basic_done(r);
        end
        PH_BH2: begin
          cur_id = cur_id + 256 * b;
          return basic_done(r);
        end
        PH_TS: begin
          shift = {shift[23:0], b};
          field_cnt++;
          if (field_cnt < 3) return 0;
          v = shift[23:0];
          tbl_ext[s] = (v == M24);
          if (fmt == FMT0) begin
            tbl_ts[s] = {8'd0, v};
            tbl_delta[s] = '0;
          end else begin
            tbl_delta[s] = {8'd0, v};
          end
          if (fmt == FMT2) return after_fields(r);
          next_field(PH_LEN);
          return 0;
        end
        PH_LEN: begin
          shift = {shift[23:0], b};
          field_cnt++;
          if (field_cnt < 3) return 0;
          tbl_len[s] = shift[23:0];
          next_field(PH_TYPE);
          return 0;
        end
        PH_TYPE: begin
          tbl_type[s] = b;
          if (fmt == FMT0) begin
            next_field(PH_SID);
            return 0;
          end
          return after_fields(r);
        end
        PH_SID: begin
          // message stream id is little endian
          shift = shift | ({24'd0, b} << (8 * (field_cnt % 4)));
          field_cnt++;
          if (field_cnt < 4) return 0;
          tbl_msgid[s] = shift;
          return after_fields(r);
        end
        PH_EXT: begin
          shift = {shift[23:0], b};
          field_cnt++;
          if (field_cnt < 4) return 0;
          if (fmt == FMT0) tbl_ts[s] = shift;
          else if (!(fmt == FMT3 && tbl_rcv[s] != 0)) tbl_delta[s] = shift;
          return header_end(r);
        end
        PH_DATA: begin
          nr = tbl_rcv[s] + 24'd1;
          lm = (nr >= tbl_len[s]);
          bytes_left = bytes_left - 24'd1;
          lc = (bytes_left == 0);
          tbl_rcv[s] = lm ? 24'd0 : nr;
          r = tagged_result(s, b, 1, lc, lm);
          if (lc) next_field(PH_BH0);
          return 1;
        end
        default: begin
          next_field(PH_BH0);
          return 0;
        end
      endcase
    endfunction

    function void note_input(logic [7:0] b);
      res_t r;
      if (step(b, r)) expected_results.push_back(r);
    endfunction

    function void cmp(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        $error("%s: expected %0h, got %0h", name, e, a);
        errors++;
      end
    endfunction

    function void check_result(res_t got);
      res_t e;
      if (expected_results.size() == 0) begin
        $error("unexpected result request: %p", got);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      cmp("payload_byte", e.payload_byte, got.payload_byte);
      cmp("has_data", e.has_data, got.has_data);
      cmp("stream_index", e.stream_index, got.stream_index);
      cmp("message_type", e.message_type, got.message_type);
      cmp("message_length", e.message_length, got.message_length);
      cmp("message_stream_id", e.message_stream_id, got.message_stream_id);
      cmp("timestamp", e.timestamp, got.timestamp);
      cmp("last_of_chunk", e.last_of_chunk, got.last_of_chunk);
      cmp("last_of_message", e.last_of_message, got.last_of_message);
      cmp("error", e.error, got.error);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic        out_ready;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [23:0] cfg_chunk_size;
  res_t        out_res;

  deframe_scoreboard sb;
  deframe_scoreboard plan;   // tracks the parser so stimulus knows where it is
  int burst_left;
  int bytes_sent;
  int idle_cycles;
  int ready_pct;
  int cycle_cnt;

  rtmp_chunk_stream_deframer_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_byte(in_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_payload_byte(out_res.payload_byte),
    .out_has_data(out_res.has_data),
    .out_stream_index(out_res.stream_index),
    .out_message_type(out_res.message_type),
    .out_message_length(out_res.message_length),
    .out_message_stream_id(out_res.message_stream_id),
    .out_timestamp(out_res.timestamp),
    .out_last_of_chunk(out_res.last_of_chunk),
    .out_last_of_message(out_res.last_of_message),
    .out_error(out_res.error),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_chunk_size(cfg_chunk_size)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // result side: check accepted requests, stall with a changing duty cycle
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_res);
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt % 256 == 0) ready_pct <= (cycle_cnt % 1024 == 0) ? 100 : $urandom_range(20, 95);
    out_ready <= ($urandom_range(1, 100) <= ready_pct);
  end

  // watchdog on cycles with no request moving on any channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // send one byte; valid stays high between back-to-back requests
  task automatic put_byte(input logic [7:0] b);
    res_t dummy;
    void'(plan.step(b, dummy));
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_input(b);
    bytes_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_chunk_size(input logic [23:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_chunk_size <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.chunk_size = v;
    plan.chunk_size = v;
  endtask

  // one chunk; header fields from arguments, remaining bytes follow the parser
  task automatic send_chunk(input logic [5:0] csid, input logic [1:0] f,
                            input logic [23:0] ts, input logic [23:0] len,
                            input bit extremes);
    logic [7:0] b;
    int k;
    k = 0;
    put_byte({f, csid});
    while (plan.phase inside {PH_TS, PH_LEN, PH_TYPE, PH_SID, PH_EXT} && !plan.halted) begin
      if (plan.phase == PH_TS) b = ts[23 - 8 * plan.field_cnt -: 8];
      else if (plan.phase == PH_LEN) b = len[23 - 8 * plan.field_cnt -: 8];
      else b = 8'($urandom);
      put_byte(b);
    end
    while (plan.phase == PH_DATA) begin
      b = extremes ? ((k % 2) ? 8'hFF : 8'h00) : 8'($urandom);
      put_byte(b);
      k++;
    end
  endtask

  task automatic random_chunk(input bit small_only);
    logic [5:0] csid;
    logic [1:0] f;
    logic [23:0] ts, len;
    csid = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(2, 63)) : 6'($urandom_range(2, 5));
    f = 2'($urandom_range(0, 3));
    ts = ($urandom_range(0, 9) == 0) ? M24 : 24'($urandom);
    if (!small_only && $urandom_range(0, 19) == 0) len = 24'($urandom_range(41, 300));
    else len = 24'($urandom_range(0, 40));
    send_chunk(csid, f, ts, len, 0);
  endtask

  // random byte, kept off the multi-byte id forms that would halt the block
  task automatic noise_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if (plan.phase == PH_BH0 && b[5:1] == 0) b[1] = 1'b1;
    put_byte(b);
  endtask

  task automatic finish_chunk();
    while (plan.phase != PH_BH0) noise_byte();
  endtask

  task automatic random_phase(input int n_bytes, input bit noisy, input bit small_only);
    int target;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      if (noisy && $urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 12)) noise_byte();
      else
        random_chunk(small_only);
    end
    finish_chunk();
  endtask

  initial begin
    sb = new();
    plan = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_byte = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_chunk_size = '0;
    burst_left = 0;
    bytes_sent = 0;
    idle_cycles = 0;
    ready_pct = 100;
    cycle_cnt = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: no prior header, extended timestamp, every fmt, empty message
    send_chunk(6'd50, FMT3, 24'd0, 24'd0, 1);
    send_chunk(6'd2, FMT0, M24, 24'd3, 1);
    send_chunk(6'd2, FMT1, 24'h000010, 24'd2, 1);
    send_chunk(6'd2, FMT2, 24'hFFFFFE, 24'd0, 1);
    send_chunk(6'd2, FMT3, 24'd0, 24'd0, 1);
    send_chunk(6'd63, FMT0, 24'd0, 24'd0, 1);
    // small chunk size, then a new header mid-message that is too short
    write_chunk_size(24'd2);
    send_chunk(6'd4, FMT0, 24'd5, 24'd6, 1);
    send_chunk(6'd4, FMT1, 24'd1, 24'd1, 1);

    // random phases over several chunk sizes
    write_chunk_size(24'd0);
    random_phase(250, 1, 0);
    write_chunk_size(24'd1);
    random_phase(250, 1, 0);
    write_chunk_size(M24);
    random_phase(300, 0, 1);
    write_chunk_size(24'd128);
    random_phase(400, 1, 0);
    write_chunk_size(24'd7);
    random_phase(300, 1, 0);
    write_chunk_size(24'($urandom_range(3, 64)));
    random_phase(400, 1, 0);

    // out-of-range stream id halts the block; later bytes are ignored
    put_byte(8'h00);
    put_byte(8'($urandom));
    repeat (3) put_byte(8'($urandom));
    wait_idle();
    repeat (20) @(posedge clk);

    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/rcsd_pkg.sv
design/rcsd_ram.sv
design/rcsd_parser.sv
design/rtmp_chunk_stream_deframer_core.sv
test/rtmp_chunk_stream_deframer_core_tb.sv
